// ===== rtl/crp_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock page replacement package
// Shared sizes, event and status codes, and the transaction types of the
// input and result channels.
// ----------------------------------------------------------------------------
package crp_pkg;

	localparam int FRAME_SLOTS = 64;
	localparam int SLOT_W      = 6;
	localparam int PAGE_W      = 36;
	localparam int SLOT_IW     = $clog2(FRAME_SLOTS);
	localparam int CNT_W       = $clog2(FRAME_SLOTS + 1);

	typedef logic [1:0] mode_t;
	typedef logic [1:0] status_t;

	localparam mode_t MODE_TOUCH  = 2'd0;
	localparam mode_t MODE_INSERT = 2'd1;
	localparam mode_t MODE_REMOVE = 2'd2;
	localparam mode_t MODE_VICTIM = 2'd3;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_NO_FRAME = 2'd1;
	localparam status_t ST_USED     = 2'd2;
	localparam status_t ST_EMPTY    = 2'd3;

	typedef struct packed {
		mode_t              mode;
		logic [SLOT_W-1:0]  slot;
		logic [PAGE_W-1:0]  page_number;
	} crp_in_t;

	typedef struct packed {
		status_t            status;
		logic               victim_valid;
		logic [SLOT_W-1:0]  victim_slot;
		logic [PAGE_W-1:0]  victim_page;
	} crp_out_t;

endpackage

// ===== rtl/clock_page_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// Clock page replacement unit
// Second-chance victim selection over a ring of frame slots, with a
// registered result channel.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_ready   in_data   (mode, slot, page_number)
//   result    out_valid / out_ready out_data  (status, victim fields)
//
// Touch, insert and remove each do one RAM read, then the update. A victim
// request scans the ring from the hand, visiting 1 to 2 * FRAME_SLOTS slots,
// one slot per cycle through the page RAM. Reset clears all control and
// occupancy state at once. One result waits in the output register while the
// next transaction executes.
// ----------------------------------------------------------------------------
module clock_page_replacement_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  crp_pkg::crp_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output crp_pkg::crp_out_t out_data
);
	import crp_pkg::*;

	logic     res_valid;
	logic     res_ready;
	crp_out_t res_data;
	logic     out_valid_q;
	crp_out_t out_q;

	crp_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	assign res_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res_data;
		end
	end

endmodule

// ===== rtl/crp_engine.sv =====
// ----------------------------------------------------------------------------
// Clock page replacement engine
// Holds the slot state: occupancy flags in flops, and the accessed bit with
// the page number in a synchronous RAM. Executes one event at a time and
// runs the pipelined second-chance scan through the RAM.
// ----------------------------------------------------------------------------
module crp_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  crp_pkg::crp_in_t  in_data,
	output logic              res_valid,
	input  logic              res_ready,
	output crp_pkg::crp_out_t res_data
);
	import crp_pkg::*;

	typedef logic [SLOT_IW-1:0] idx_t;
	typedef logic [PAGE_W:0]    entry_t;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_RESP = 2'd3;

	function automatic idx_t to_idx(logic [SLOT_W-1:0] s);
		logic [SLOT_IW+SLOT_W-1:0] w;
		w = {{SLOT_IW{1'b0}}, s};
		return w[SLOT_IW-1:0];
	endfunction

	function automatic logic in_range(logic [SLOT_W-1:0] s);
		logic [SLOT_IW+SLOT_W-1:0] w;
		w = {{SLOT_IW{1'b0}}, s};
		return w < (SLOT_IW+SLOT_W)'(FRAME_SLOTS);
	endfunction

	function automatic logic [SLOT_W-1:0] to_field(idx_t p);
		logic [SLOT_IW+SLOT_W-1:0] w;
		w = {{SLOT_W{1'b0}}, p};
		return w[SLOT_W-1:0];
	endfunction

	function automatic idx_t next_pos(idx_t p);
		return (p == idx_t'(FRAME_SLOTS - 1)) ? '0 : p + idx_t'(1);
	endfunction

	logic [1:0]             state_q, state_d;
	crp_in_t                req_q;
	crp_out_t               res_q;
	logic [FRAME_SLOTS-1:0] occ_q;
	logic [CNT_W-1:0]       occ_count_q;
	idx_t                   hand_q;
	idx_t                   rd_pos_q;
	idx_t                   pos_s1;

	entry_t                 mem [FRAME_SLOTS];
	entry_t                 rdata_q;
	logic                   mem_we;
	idx_t                   mem_wa;
	idx_t                   mem_ra;
	entry_t                 mem_wd;

	idx_t                   req_idx;
	logic                   req_ok;
	logic                   req_occ;
	logic                   occ_set;
	logic                   occ_clr;
	logic                   scan_start;
	logic                   scan_hit;

	assign req_idx  = to_idx(req_q.slot);
	assign req_ok   = in_range(req_q.slot);
	assign req_occ  = req_ok && occ_q[req_idx];
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		res_valid  = 1'b0;
		res_data   = '0;
		mem_we     = 1'b0;
		mem_wa     = req_idx;
		mem_wd     = {1'b0, req_q.page_number};
		mem_ra     = to_idx(in_data.slot);
		occ_set    = 1'b0;
		occ_clr    = 1'b0;
		scan_start = 1'b0;
		scan_hit   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				res_valid = 1'b1;
				res_data.status = ST_OK;
				state_d = res_ready ? S_IDLE : S_RESP;
				case (req_q.mode)
					MODE_TOUCH: begin
						if (req_occ) begin
							mem_we = 1'b1;
							mem_wd = {1'b1, rdata_q[PAGE_W-1:0]};
						end else begin
							res_data.status = ST_EMPTY;
						end
					end
					MODE_INSERT: begin
						if (req_ok && !req_occ) begin
							mem_we  = 1'b1;
							occ_set = 1'b1;
						end else begin
							res_data.status = ST_USED;
						end
					end
					MODE_REMOVE: begin
						if (req_occ) begin
							occ_clr = 1'b1;
						end else begin
							res_data.status = ST_EMPTY;
						end
					end
					default: begin
						if (occ_count_q == '0) begin
							res_data.status = ST_NO_FRAME;
						end else begin
							res_valid  = 1'b0;
							state_d    = S_SCAN;
							mem_ra     = hand_q;
							scan_start = 1'b1;
						end
					end
				endcase
			end
			S_SCAN: begin
				mem_ra = rd_pos_q;
				if (occ_q[pos_s1]) begin
					if (rdata_q[PAGE_W]) begin
						mem_we = 1'b1;
						mem_wa = pos_s1;
						mem_wd = {1'b0, rdata_q[PAGE_W-1:0]};
					end else begin
						scan_hit              = 1'b1;
						res_valid             = 1'b1;
						res_data.status       = ST_OK;
						res_data.victim_valid = 1'b1;
						res_data.victim_slot  = to_field(pos_s1);
						res_data.victim_page  = rdata_q[PAGE_W-1:0];
						state_d = res_ready ? S_IDLE : S_RESP;
					end
				end
			end
			S_RESP: begin
				res_valid = 1'b1;
				res_data  = res_q;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			occ_count_q <= '0;
			hand_q      <= '0;
			rd_pos_q    <= '0;
			pos_s1      <= '0;
		end else begin
			state_q <= state_d;
			if (occ_set) begin
				occ_q[req_idx] <= 1'b1;
				occ_count_q    <= occ_count_q + CNT_W'(1);
			end else if (occ_clr) begin
				occ_q[req_idx] <= 1'b0;
				occ_count_q    <= occ_count_q - CNT_W'(1);
			end
			if (scan_start) begin
				pos_s1   <= hand_q;
				rd_pos_q <= next_pos(hand_q);
			end else if (state_q == S_SCAN && !scan_hit) begin
				pos_s1   <= rd_pos_q;
				rd_pos_q <= next_pos(rd_pos_q);
			end
			if (scan_hit) begin
				hand_q <= pos_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_data;
		end
		if (res_valid && !res_ready && state_q != S_RESP) begin
			res_q <= res_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[mem_ra];
	end

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		occ_count_q == CNT_W'($countones(occ_q)))
		else $error("occupied count differs from the occupied flags");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> occ_count_q != '0)
		else $error("victim scan running with no occupied slot");

	a_exec_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_EXEC)
		else $error("accepted transaction did not enter execution");

	a_hand_on_victim: assert property (@(posedge clk) disable iff (!arst_n)
		scan_hit |=> hand_q == $past(pos_s1) && occ_q[hand_q])
		else $error("hand not left on an occupied victim slot");

endmodule

// ===== tb/sv/victim_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock page replacement scoreboard
// Tracks the frame ring, the accessed bits and the hand for every accepted
// event transaction, and checks each result transaction against the oldest
// predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package victim_scoreboard_pkg;

	import crp_pkg::*;

	class victim_scoreboard;

		bit                frame_used     [FRAME_SLOTS];
		bit                frame_accessed [FRAME_SLOTS];
		bit [PAGE_W-1:0]   frame_page     [FRAME_SLOTS];
		int                clock_hand;
		crp_out_t          expected_results [$];
		int                errors;

		function int pending();
			return expected_results.size();
		endfunction

		function void note_event(crp_in_t ev);
			crp_out_t r;
			int       s;
			int       pos;
			bit       any;
			r = '0;
			s = int'(ev.slot);
			case (ev.mode)
				MODE_TOUCH: begin
					if (s >= FRAME_SLOTS || !frame_used[s]) begin
						r.status = ST_EMPTY;
					end else begin
						frame_accessed[s] = 1'b1;
						r.status = ST_OK;
					end
				end
				MODE_INSERT: begin
					if (s >= FRAME_SLOTS || frame_used[s]) begin
						r.status = ST_USED;
					end else begin
						frame_used[s]     = 1'b1;
						frame_accessed[s] = 1'b0;
						frame_page[s]     = ev.page_number;
						r.status = ST_OK;
					end
				end
				MODE_REMOVE: begin
					if (s >= FRAME_SLOTS || !frame_used[s]) begin
						r.status = ST_EMPTY;
					end else begin
						frame_used[s]     = 1'b0;
						frame_accessed[s] = 1'b0;
						r.status = ST_OK;
					end
				end
				MODE_VICTIM: begin
					any = 1'b0;
					foreach (frame_used[n])
						if (frame_used[n])
							any = 1'b1;
					pos = (clock_hand < FRAME_SLOTS) ? clock_hand : 0;
					r.status = ST_NO_FRAME;
					if (any) begin
						for (int n = 0; n < 2 * FRAME_SLOTS; n++) begin
							if (frame_used[pos]) begin
								if (!frame_accessed[pos]) begin
									clock_hand     = pos;
									r.status       = ST_OK;
									r.victim_valid = 1'b1;
									r.victim_slot  = pos[SLOT_W-1:0];
									r.victim_page  = frame_page[pos];
									break;
								end
								frame_accessed[pos] = 1'b0;
							end
							pos = (pos + 1) % FRAME_SLOTS;
						end
					end
				end
				default: begin
					r.status = ST_NO_FRAME;
				end
			endcase
			expected_results.push_back(r);
		endfunction

		function void report_field(string name, longint unsigned want, longint unsigned got);
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		endfunction

		function void check_result(crp_out_t got);
			crp_out_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result transaction, expected none actual %0h",
					$time, got);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (got.status !== want.status)
				report_field("status", 64'(want.status), 64'(got.status));
			if (got.victim_valid !== want.victim_valid)
				report_field("victim_valid", 64'(want.victim_valid),
					64'(got.victim_valid));
			if (got.victim_slot !== want.victim_slot)
				report_field("victim_slot", 64'(want.victim_slot), 64'(got.victim_slot));
			if (got.victim_page !== want.victim_page)
				report_field("victim_page", 64'(want.victim_page), 64'(got.victim_page));
		endfunction

	endclass

endpackage

// ===== tb/sv/tb_clock_page_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// Clock page replacement unit testbench
// Drives directed and random touch, insert, remove and victim events through
// the valid/ready input channel under several idling patterns, and checks
// every result transaction against a second-chance predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_clock_page_replacement_unit;

	import crp_pkg::*;
	import victim_scoreboard_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 300;
	localparam int PHASE_ITEMS    = 270;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	crp_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	crp_out_t out_data;

	victim_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int ins_pct;
	int idle_cycles = 0;

	clock_page_replacement_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("clock_page_replacement_unit: mismatch");
				$finish;
			end
		end
	end

	task automatic send_item(crp_in_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_event(item);
	endtask

	task automatic send_event(mode_t mode, int slot, logic [PAGE_W-1:0] page);
		crp_in_t ev;
		ev.mode        = mode;
		ev.slot        = slot[SLOT_W-1:0];
		ev.page_number = page;
		send_item(ev);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_slot(bit want_used);
		int s;
		s = 0;
		repeat (8) begin
			s = $urandom_range(FRAME_SLOTS - 1);
			if (sb.frame_used[s] == want_used)
				return s;
		end
		return s;
	endfunction

	function automatic crp_in_t random_event();
		crp_in_t ev;
		int      roll;
		ev.slot              = SLOT_W'($urandom_range(FRAME_SLOTS - 1));
		ev.page_number[31:0] = $urandom();
		ev.page_number[35:32] = 4'($urandom_range(15));
		roll = $urandom_range(99);
		if (roll < ins_pct) begin
			ev.mode = MODE_INSERT;
			ev.slot = SLOT_W'(pick_slot(1'b0));
		end else if (roll < 50) begin
			ev.mode = MODE_TOUCH;
			ev.slot = SLOT_W'(pick_slot(1'b1));
		end else if (roll < 70) begin
			ev.mode = MODE_REMOVE;
			ev.slot = SLOT_W'(pick_slot(1'b1));
		end else if (roll < 95) begin
			ev.mode = MODE_VICTIM;
		end else begin
			ev.mode = mode_t'($urandom_range(3));
		end
		return ev;
	endfunction

	task automatic run_random(int count);
		int sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) == 0) begin
				for (int s = 0; s < FRAME_SLOTS; s++) begin
					if (sb.frame_used[s]) begin
						send_event(MODE_TOUCH, s, '0);
						sent++;
					end
				end
				send_event(MODE_VICTIM, 0, '0);
			end else begin
				send_item(random_event());
			end
			sent++;
		end
	endtask

	task automatic run_directed();
		send_event(MODE_VICTIM, 0, '0);
		send_event(MODE_TOUCH, 5, '0);
		send_event(MODE_REMOVE, 5, '0);
		send_event(MODE_INSERT, 0, '0);
		send_event(MODE_INSERT, FRAME_SLOTS - 1, '1);
		send_event(MODE_INSERT, 0, 36'h1_2345_6789);
		send_event(MODE_TOUCH, 0, '1);
		send_event(MODE_TOUCH, FRAME_SLOTS - 1, '0);
		send_event(MODE_VICTIM, 63, '1);
		send_event(MODE_VICTIM, 0, '0);
		send_event(MODE_REMOVE, 0, '0);
		send_event(MODE_VICTIM, 0, '0);
		send_event(MODE_INSERT, 42, 36'hA_5A5A_5A5A);
		send_event(MODE_INSERT, 21, 36'h5_A5A5_A5A5);
		send_event(MODE_TOUCH, 63, '0);
		send_event(MODE_TOUCH, 21, '0);
		send_event(MODE_TOUCH, 42, '0);
		send_event(MODE_VICTIM, 0, '0);
		send_event(MODE_VICTIM, 0, '0);
		send_event(MODE_REMOVE, 63, '0);
		send_event(MODE_REMOVE, 42, '0);
		send_event(MODE_REMOVE, 21, '0);
		send_event(MODE_REMOVE, 21, '0);
		send_event(MODE_VICTIM, 0, '0);
	endtask

	initial begin
		sb = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		ins_pct        = 35;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		for (int phase = 0; phase < 4; phase++) begin
			drain_results();
			case (phase)
				0: begin
					send_idle_pct = 0;  recv_stall_pct = 0;  ins_pct = 35;
				end
				1: begin
					send_idle_pct = 75; recv_stall_pct = 0;  ins_pct = 15;
				end
				2: begin
					send_idle_pct = 0;  recv_stall_pct = 75; ins_pct = 30;
				end
				default: begin
					send_idle_pct = 10; recv_stall_pct = 10; ins_pct = 20;
				end
			endcase
			run_random(PHASE_ITEMS);
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("clock_page_replacement_unit: match");
		else
			$display("clock_page_replacement_unit: mismatch");
		$finish;
	end

endmodule

// ===== clock_page_replacement_unit.f =====
rtl/crp_pkg.sv
rtl/crp_engine.sv
rtl/clock_page_replacement_unit.sv
tb/sv/victim_scoreboard_pkg.sv
tb/sv/tb_clock_page_replacement_unit.sv
